### hdl/b32_pkg.sv
// Shared types, constants and the symbol alphabet of the base32 byte encoder.
package b32_pkg;

	localparam int SYM_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int MAX_SYMS   = 3;
	localparam int NSYM_W     = 2;
	localparam int NPAD_W     = 3;
	localparam int CNT_W      = 3;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_ONE = 8'h31;

	localparam logic [SYM_W-1:0] SYM_O    = 5'd14;
	localparam logic [SYM_W-1:0] SYM_ONE  = 5'd25;

	// Group positions of a byte within its five-byte group
	localparam logic [2:0] POS_0 = 3'd0;
	localparam logic [2:0] POS_1 = 3'd1;
	localparam logic [2:0] POS_2 = 3'd2;
	localparam logic [2:0] POS_3 = 3'd3;
	localparam logic [2:0] POS_4 = 3'd4;

	// One classified byte: the symbols it completes and the pads that follow them
	typedef struct packed {
		logic [MAX_SYMS-1:0][SYM_W-1:0] sym;
		logic [NSYM_W-1:0]              nsym;
		logic [NPAD_W-1:0]              npad;
		logic                           last;
	} cmd_t;

	// A-Z without O, then 1-7
	function automatic logic [BYTE_W-1:0] sym_to_char(input logic [SYM_W-1:0] s);
		logic [BYTE_W-1:0] c;
		if (s < SYM_O)
			c = CHAR_A + {3'b000, s};
		else if (s < SYM_ONE)
			c = CHAR_A + {3'b000, s} + 8'd1;
		else
			c = CHAR_ONE + {3'b000, s - SYM_ONE};
		return c;
	endfunction

endpackage

### hdl/b32_front.sv
// Front end: accepts bytes, tracks the group position and splits each byte into symbols.
module b32_front import b32_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  logic              cmd_full
);

	logic [2:0]        pos_q;
	logic [BYTE_W-1:0] prev_q;
	logic [2:0]        pos_nxt;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] p;

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;
	assign b        = data_byte;
	assign p        = prev_q;

	always_comb begin
		cmd.sym  = '0;
		cmd.nsym = '0;
		cmd.npad = '0;
		cmd.last = last_byte;
		pos_nxt  = POS_1;
		case (pos_q)
			POS_1: begin
				cmd.sym[0] = {p[2:0], b[7:6]};
				cmd.sym[1] = b[5:1];
				cmd.sym[2] = {b[0], 4'b0000};
				cmd.nsym   = last_byte ? 2'd3 : 2'd2;
				cmd.npad   = last_byte ? 3'd3 : 3'd0;
				pos_nxt    = POS_2;
			end
			POS_2: begin
				cmd.sym[0] = {p[0], b[7:4]};
				cmd.sym[1] = {b[3:0], 1'b0};
				cmd.nsym   = last_byte ? 2'd2 : 2'd1;
				cmd.npad   = last_byte ? 3'd2 : 3'd0;
				pos_nxt    = POS_3;
			end
			POS_3: begin
				cmd.sym[0] = {p[3:0], b[7]};
				cmd.sym[1] = b[6:2];
				cmd.sym[2] = {b[1:0], 3'b000};
				cmd.nsym   = last_byte ? 2'd3 : 2'd2;
				cmd.npad   = last_byte ? 3'd1 : 3'd0;
				pos_nxt    = POS_4;
			end
			POS_4: begin
				cmd.sym[0] = {p[1:0], b[7:5]};
				cmd.sym[1] = b[4:0];
				cmd.nsym   = 2'd2;
				pos_nxt    = POS_0;
			end
			default: begin
				// start of a group; unreachable codes fall here too
				cmd.sym[0] = b[7:3];
				cmd.sym[1] = {b[2:0], 2'b00};
				cmd.nsym   = last_byte ? 2'd2 : 2'd1;
				cmd.npad   = last_byte ? 3'd4 : 3'd0;
				pos_nxt    = POS_1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_0;
			prev_q <= '0;
		end else if (cmd_push) begin
			pos_q  <= last_byte ? POS_0 : pos_nxt;
			prev_q <= last_byte ? '0 : b;
		end
	end

endmodule

### hdl/b32_cmdq.sv
// Short command queue between the front end and the character sequencer.
module b32_cmdq import b32_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	cmd_t               ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_q;
	logic [CMDQ_AW-1:0] rd_q;
	logic [CMDQ_AW:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/b32_back.sv
// Back end: commands to characters, one per cycle while the output register is free.
module b32_back import b32_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_char,
	output logic              last_char
);

	cmd_t              cur_q;
	logic              cur_vld_q;
	logic [CNT_W-1:0]  idx_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              out_last_q;
	logic              out_vld_q;

	logic [CNT_W-1:0]  total;
	logic              at_end;
	logic              out_free;
	logic              emit;
	logic              cur_done;
	logic [SYM_W-1:0]  sym_sel;
	logic [BYTE_W-1:0] char_nxt;

	assign total    = CNT_W'(cur_q.nsym) + cur_q.npad;
	assign at_end   = (idx_q == total - 1'b1);
	assign out_free = !out_vld_q || pop;
	assign emit     = cur_vld_q && out_free;
	assign cur_done = emit && at_end;
	assign cmd_pop  = (!cur_vld_q || cur_done) && !cmd_empty;

	always_comb begin
		case (idx_q[1:0])
			2'd0:    sym_sel = cur_q.sym[0];
			2'd1:    sym_sel = cur_q.sym[1];
			2'd2:    sym_sel = cur_q.sym[2];
			default: sym_sel = '0;
		endcase
		char_nxt = (idx_q < CNT_W'(cur_q.nsym)) ? sym_to_char(sym_sel) : PAD_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// advance through the current command, refill from the queue
			if (cmd_pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (cur_done) begin
				cur_vld_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd;
		if (emit) begin
			out_char_q <= char_nxt;
			out_last_q <= cur_q.last && at_end;
		end
	end

	assign empty     = !out_vld_q;
	assign out_char  = out_char_q;
	assign last_char = out_last_q;

endmodule

### hdl/base32_byte_encoder.sv
// Top level of the base32 byte encoder: front end, command queue and character back end.
//
//   channel   direction  handshake            word
//   input     in         push / full          data_byte, last_byte
//   result    out        pop / empty          out_char, last_char
//
// Cycles: a byte is taken every cycle while the command queue has room; the back
// end issues one character per cycle while the output register is free, so a steady
// stream carries 8 characters per 5 bytes, its pace set by the single character output register.
// With the back end idle, an accepted byte passes through the queue entry, the current
// command register and the output register before its first character appears.
// Reset: arst_n clears group position, previous byte, queue pointers and valids.
// Stalls: with pop held low the output register holds; the queue (4 commands) keeps
// taking bytes until it fills, then full rises.
module base32_byte_encoder import b32_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_char,
	output logic              last_char
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	// classify each byte into its symbols and pad count
	b32_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// decouple byte intake from character issue
	b32_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	// drain commands one character at a time
	b32_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

### hdl/b32_checker.sv
// Port-level checks for the base32 byte encoder and their binding to the top level.
module b32_checker import b32_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input logic [BYTE_W-1:0] out_char,
	input logic              last_char
);

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
		else $error("stalled result word changed");

	// an accepted byte must be followed by a pending result
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##3 !empty)
		else $error("no result after accepted byte");

	// the queue only fills while characters are waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input blocked with no result pending");

endmodule

bind base32_byte_encoder b32_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_char  (out_char),
	.last_char (last_char)
);
